>>> src/tkm_pkg.sv
// Package for the top-K maximum tracker: sizes, item types and state codes.
// No dependencies; used by the top level top_k_max_tracker.
`timescale 1ns / 1ps
`default_nettype none

package tkm_pkg;

    // Number of ranked entries the list can hold.
    localparam int CAPACITY  = 16;
    // Index into the list and a count that can reach CAPACITY.
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    // Fixed field widths.
    localparam int TIME_W    = 32;
    localparam int TAG_W     = 16;
    localparam int STAMP_W   = 32;
    localparam int RANK_W    = 4;
    localparam int NUM_REC_W = 5;

    // One input item.
    typedef struct packed {
        logic [TIME_W-1:0]  elapsed_us;
        logic [TAG_W-1:0]   source_tag;
        logic [STAMP_W-1:0] stamp;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [TIME_W-1:0]  entry_elapsed;
        logic [TAG_W-1:0]   entry_tag;
        logic [STAMP_W-1:0] entry_stamp;
        logic               new_here;
        logic               last;
    } t_out_item;

    // One stored list entry.
    typedef struct packed {
        logic [TIME_W-1:0]  elapsed;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

endpackage

`default_nettype wire

>>> src/top_k_max_tracker.sv
// An item scans the stored list one entry per cycle until it finds its slot or reaches the end,
// then rewrites and emits the list one entry per cycle; an item that finds no slot in a list
// already at its kept count is dropped. A new item is taken only while busy is low, so the
// block takes no item before it is through with the last; both passes walk through the single
// read port of the entry RAM. Results are registered and appear in the cycle after their
// entry is rewritten, in a continuous burst; the receiver cannot stall. Reset (synchronous,
// active low) empties the list and sets the kept count to one.
`timescale 1ns / 1ps
`default_nettype none

module top_k_max_tracker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire tkm_pkg::t_in_item  i_item,
    input  wire logic               i_cfg_we,
    input  wire logic [4:0]         i_cfg_data,
    output logic                    o_strobe,
    output tkm_pkg::t_out_item      o_result
);

    import tkm_pkg::*;

    t_state                r_state,       n_state;
    logic [IDX_W-1:0]      r_idx,         n_idx;
    logic [CNT_W-1:0]      r_pos,         n_pos;
    logic [CNT_W-1:0]      r_newcnt,      n_newcnt;
    logic [CNT_W-1:0]      r_fill,        n_fill;
    logic [CNT_W-1:0]      r_limit,       n_limit;
    logic [NUM_REC_W-1:0]  r_num_records;
    t_in_item              r_item,        n_item;
    t_entry                r_carry,       n_carry;
    logic                  r_strobe,      n_strobe;
    t_out_item             r_out,         n_out;

    logic                  accept;
    logic [CNT_W-1:0]      eff_limit;
    logic [CNT_W-1:0]      idx_ext;
    logic [CNT_W-1:0]      grow_cnt;
    logic                  hit;
    logic                  at_end;
    logic [IDX_W-1:0]      raddr;
    logic                  we;
    t_entry                wdata;
    t_entry                rd;
    t_entry                new_entry;

    assign accept    = start && !busy;
    assign busy      = (r_state != ST_IDLE);
    assign idx_ext   = CNT_W'(r_idx);
    assign new_entry = '{elapsed: r_item.elapsed_us, tag: r_item.source_tag,
                         stamp: r_item.stamp};

    // Kept count as used: zero acts as one, above capacity acts as capacity.
    always_comb begin
        if (r_num_records == '0) begin
            eff_limit = CNT_W'(1);
        end else if (int'(r_num_records) > CAPACITY) begin
            eff_limit = CNT_W'(CAPACITY);
        end else begin
            eff_limit = CNT_W'(r_num_records);
        end
    end

    // Scan compare and the list length after an insert.
    assign hit      = (r_item.elapsed_us > rd.elapsed);
    assign at_end   = (idx_ext == r_fill - CNT_W'(1));
    assign grow_cnt = (r_fill < r_limit) ? (r_fill + CNT_W'(1)) : r_limit;

    // Entry memory.
    tkm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_idx),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    // Controller: scan for the slot, then shift, write back and emit; an item with no slot in a full list is dropped.
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_newcnt = r_newcnt;
        n_fill   = r_fill;
        n_limit  = r_limit;
        n_item   = r_item;
        n_carry  = r_carry;
        n_strobe = 1'b0;
        n_out    = r_out;
        raddr    = '0;
        we       = 1'b0;
        wdata    = new_entry;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_item  = i_item;
                    n_limit = eff_limit;
                    n_idx   = '0;
                    if (r_fill == '0) begin
                        n_pos    = '0;
                        n_newcnt = CNT_W'(1);
                        n_state  = ST_EMIT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    n_pos    = idx_ext;
                    n_newcnt = grow_cnt;
                    n_idx    = '0;
                    n_state  = ST_EMIT;
                end else if (at_end) begin
                    n_idx = '0;
                    if (r_fill >= r_limit) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos    = r_fill;
                        n_newcnt = grow_cnt;
                        n_state  = ST_EMIT;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                    raddr = r_idx + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                raddr = r_idx + IDX_W'(1);
                // Above the slot the stored entry stays; below it the displaced one moves down.
                if (idx_ext < r_pos) begin
                    wdata = rd;
                end else if (idx_ext == r_pos) begin
                    wdata = new_entry;
                end else begin
                    wdata = r_carry;
                end
                we      = (idx_ext >= r_pos);
                n_carry = rd;

                n_strobe            = 1'b1;
                n_out.rank          = RANK_W'(r_idx);
                n_out.entry_elapsed = wdata.elapsed;
                n_out.entry_tag     = wdata.tag;
                n_out.entry_stamp   = wdata.stamp;
                n_out.new_here      = (idx_ext == r_pos);
                n_out.last          = (idx_ext == r_newcnt - CNT_W'(1));

                if (idx_ext == r_newcnt - CNT_W'(1)) begin
                    n_fill  = r_newcnt;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_fill        <= '0;
            r_strobe      <= 1'b0;
            r_num_records <= NUM_REC_W'(1);
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_num_records <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_newcnt <= n_newcnt;
        r_limit  <= n_limit;
        r_item   <= n_item;
        r_carry  <= n_carry;
        r_out    <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // The list never grows past its capacity.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) <= CAPACITY)
        else $error("list fill count exceeds capacity");

    // A burst of results runs without gaps until its last item.
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |=> o_strobe)
        else $error("result burst broken before its last item");

    // The entry marked as new carries the elapsed time of the item just taken.
    a_new_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.new_here |-> o_result.entry_elapsed == r_item.elapsed_us)
        else $error("new entry does not match the inserted item");

    // An accepted item always keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not start work");

    // Results only come out while the list is being rewritten or right after.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == ST_EMIT)
        else $error("result emitted outside the emit pass");

endmodule

`default_nettype wire

>>> src/tkm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
